// ----- src/pdtt_pkg.sv -----
// Shared types and constants for the per-port decision table with aging.
// No dependencies.
package pdtt_pkg;

   localparam int PORT_COUNT_DEF  = 65536;
   localparam int STAMP_WIDTH_DEF = 32;

   localparam int ACTION_W = 3;
   localparam int PORT_W   = 16;
   localparam int NOW_W    = 32;
   localparam int TTL_W    = 16;

   localparam logic [TTL_W-1:0] TTL_RESET = 16'd30;

   typedef enum logic [ACTION_W-1:0] {
      ACT_QUERY_DECIDED = 3'd0,
      ACT_QUERY_DIRECT  = 3'd1,
      ACT_SET_DIRECT    = 3'd2,
      ACT_SET_DECIDED   = 3'd3,
      ACT_CLEAR         = 3'd4,
      ACT_EXPIRE_SWEEP  = 3'd5,
      ACT_CLEAR_ALL     = 3'd6
   } action_type;

endpackage

// ----- src/pdtt_chan_if.sv -----
// Valid/ready channel interfaces for request and response items.
// Depends on pdtt_pkg.
interface pdtt_req_if import pdtt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [PORT_W-1:0]   port;
   logic [NOW_W-1:0]    time_bucket;

   modport source (output valid, output action, output port, output time_bucket, input ready);
   modport sink   (input valid, input action, input port, input time_bucket, output ready);
endinterface

interface pdtt_rsp_if ();
   logic valid;
   logic ready;
   logic answer;

   modport source (output valid, output answer, input ready);
   modport sink   (input valid, input answer, output ready);
endinterface

// ----- src/pdtt_ram.sv -----
// Single-port-write, single-port-read table memory, registered read data.
// No dependencies.
module pdtt_ram #(
   parameter int DEPTH  = 65536,
   parameter int DATA_W = 34,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- src/pdtt_ctrl.sv -----
// Sequencer: per-item read-modify-write, expire sweep, clear passes, response register.
// Depends on pdtt_pkg and the channel interfaces.
module pdtt_ctrl import pdtt_pkg::*; #(
   parameter int PORT_COUNT  = PORT_COUNT_DEF,
   parameter int STAMP_WIDTH = STAMP_WIDTH_DEF,
   parameter int ADDR_W      = $clog2(PORT_COUNT),
   parameter int DATA_W      = STAMP_WIDTH + 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [TTL_W-1:0]  ttl,
   pdtt_req_if.sink          req,
   pdtt_rsp_if.source        rsp,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [DATA_W-1:0] rd_data,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [DATA_W-1:0] wr_data
);

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_LOOKUP, ST_SWEEP, ST_DRAIN, ST_WIPE, ST_FINISH
   } state_type;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PORT_COUNT - 1);

   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      cnt_ff, cnt_in;
   logic                   chk_ff, chk_in;
   logic [ADDR_W-1:0]      chk_addr_ff, chk_addr_in;
   action_type             act_ff, act_in;
   logic                   in_range_ff, in_range_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [STAMP_WIDTH-1:0] now_ff, now_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   answer_ff, answer_in;

   logic                   accept;
   logic                   slot_free;
   logic                   ent_decided;
   logic                   ent_direct;
   logic [STAMP_WIDTH-1:0] ent_stamp;
   logic [STAMP_WIDTH-1:0] age;
   logic                   stale;
   logic [STAMP_WIDTH-1:0] new_stamp;

   assign ent_decided = rd_data[DATA_W-1];
   assign ent_direct  = rd_data[DATA_W-2];
   assign ent_stamp   = rd_data[STAMP_WIDTH-1:0];
   assign age         = now_ff - ent_stamp;
   assign stale       = (ent_stamp == '0) || (32'(age) > 32'(ttl));
   assign new_stamp   = (now_ff == '0) ? STAMP_WIDTH'(1) : now_ff;

   assign slot_free   = !rsp_valid_ff || rsp.ready;
   assign req.ready   = (state_ff == ST_IDLE);
   assign accept      = req.valid && req.ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.answer  = answer_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      chk_in       = chk_ff;
      chk_addr_in  = chk_addr_ff;
      act_in       = act_ff;
      in_range_in  = in_range_ff;
      addr_in      = addr_ff;
      now_in       = now_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      answer_in    = answer_ff;
      rd_en        = 1'b0;
      rd_addr      = cnt_ff;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff;
      wr_data      = '0;

      case (state_ff)
         ST_INIT: begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               act_in      = action_type'(req.action);
               addr_in     = req.port[ADDR_W-1:0];
               in_range_in = 17'(req.port) < 17'(PORT_COUNT);
               now_in      = req.time_bucket[STAMP_WIDTH-1:0];
               cnt_in      = '0;
               chk_in      = 1'b0;
               case (action_type'(req.action))
                  ACT_EXPIRE_SWEEP: state_in = ST_SWEEP;
                  ACT_CLEAR_ALL:    state_in = ST_WIPE;
                  default: begin
                     rd_en    = 1'b1;
                     rd_addr  = req.port[ADDR_W-1:0];
                     state_in = ST_LOOKUP;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            if (slot_free) begin
               wr_addr      = addr_ff;
               answer_in    = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (in_range_ff) begin
                  case (act_ff)
                     ACT_QUERY_DECIDED: begin
                        if (ent_decided) begin
                           if (stale) begin
                              wr_en = 1'b1;
                           end else begin
                              answer_in = 1'b1;
                           end
                        end
                     end
                     ACT_QUERY_DIRECT: answer_in = ent_direct;
                     ACT_SET_DIRECT, ACT_SET_DECIDED: begin
                        wr_en   = 1'b1;
                        wr_data = {1'b1, act_ff == ACT_SET_DIRECT, new_stamp};
                     end
                     ACT_CLEAR: wr_en = 1'b1;
                     default: ;
                  endcase
               end
            end
         end
         ST_SWEEP, ST_DRAIN: begin
            // rd_data holds the entry read last cycle at chk_addr_ff
            wr_addr = chk_addr_ff;
            wr_en   = chk_ff && (ent_stamp != '0) && stale;
            if (state_ff == ST_SWEEP) begin
               rd_en       = 1'b1;
               chk_in      = 1'b1;
               chk_addr_in = cnt_ff;
               cnt_in      = cnt_ff + 1'b1;
               if (cnt_ff == LAST_ADDR) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               chk_in   = 1'b0;
               state_in = ST_FINISH;
            end
         end
         ST_WIPE: begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               answer_in    = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chk_addr_ff <= chk_addr_in;
      act_ff      <= act_in;
      in_range_ff <= in_range_in;
      addr_ff     <= addr_in;
      now_ff      <= now_in;
      answer_ff   <= answer_in;
   end

endmodule

// ----- src/port_decision_ttl_table.sv -----
// Per-port decision table with time-bucket aging. A port action reads its entry and
// registers the response once the response slot is free; no new item is accepted
// until then. Expire sweep and clear all each make a pass over the whole table, both
// bound by the single table write port. Synchronous reset clears ttl to 30 and starts
// a clearing pass over the table; no item is accepted until it ends.
module port_decision_ttl_table import pdtt_pkg::*; #(
   parameter int PORT_COUNT  = PORT_COUNT_DEF,
   parameter int STAMP_WIDTH = STAMP_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [TTL_W-1:0] csr_wr_data,
   pdtt_req_if.sink         req_ch,
   pdtt_rsp_if.source       rsp_ch
);

   localparam int ADDR_W = $clog2(PORT_COUNT);
   localparam int DATA_W = STAMP_WIDTH + 2;

   logic [TTL_W-1:0]  ttl_ff;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= TTL_RESET;
      end else if (csr_wr_en) begin
         ttl_ff <= csr_wr_data;
      end
   end

   pdtt_ctrl #(
      .PORT_COUNT  (PORT_COUNT),
      .STAMP_WIDTH (STAMP_WIDTH),
      .ADDR_W      (ADDR_W),
      .DATA_W      (DATA_W)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .ttl     (ttl_ff),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   pdtt_ram #(
      .DEPTH  (PORT_COUNT),
      .DATA_W (DATA_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

endmodule

// ----- tb/sv/pdtt_answer_checker.sv -----
// Answer checker for the per-port decision table: watches the request, response and
// CSR ports, keeps its own copy of the aged table and compares every answer in order.
// Depends on pdtt_pkg and the pdtt_req_if / pdtt_rsp_if interfaces.
`timescale 1ns / 100ps

module pdtt_answer_checker import pdtt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [TTL_W-1:0] csr_wr_data,
   pdtt_req_if              req_mon,
   pdtt_rsp_if              rsp_mon,
   output int               outstanding,
   output int               mismatch_count,
   output int               items_seen,
   output int               answers_checked,
   output int               table_passes
);

   localparam int MAX_PRINTED = 40;

   typedef struct {
      logic                       decided;
      logic                       direct;
      logic [STAMP_WIDTH_DEF-1:0] stamp;
   } port_entry_type;

   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [PORT_W-1:0]   port;
      logic [NOW_W-1:0]    time_bucket;
      logic                answer;
   } answer_type;

   port_entry_type   port_table[int unsigned];
   answer_type       expected_answers[$];
   logic [TTL_W-1:0] ttl;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("MISMATCH at %0t: %s", $realtime, what);
      end
   endtask

   function automatic logic entry_stale(input port_entry_type e, input logic [NOW_W-1:0] now);
      logic [STAMP_WIDTH_DEF-1:0] age;
      age = now[STAMP_WIDTH_DEF-1:0] - e.stamp;
      return (e.stamp == '0) || (age > ttl);
   endfunction

   // Applies one item to the table copy and returns the answer it should produce.
   function automatic logic predict_answer(input logic [ACTION_W-1:0] act,
                                           input logic [PORT_W-1:0]   port,
                                           input logic [NOW_W-1:0]    now);
      int unsigned    key;
      int unsigned    stale_keys[$];
      logic           in_range;
      logic           answer;
      port_entry_type e;
      key      = port;
      in_range = key < PORT_COUNT_DEF;
      answer   = 1'b0;
      case (act)
         ACT_QUERY_DECIDED: begin
            if (in_range && port_table.exists(key) && port_table[key].decided) begin
               if (entry_stale(port_table[key], now)) begin
                  port_table.delete(key);
               end else begin
                  answer = 1'b1;
               end
            end
         end
         ACT_QUERY_DIRECT: begin
            if (in_range && port_table.exists(key)) begin
               answer = port_table[key].direct;
            end
         end
         ACT_SET_DIRECT, ACT_SET_DECIDED: begin
            if (in_range) begin
               e.decided       = 1'b1;
               e.direct        = (act == ACT_SET_DIRECT);
               e.stamp         = (now == '0) ? NOW_W'(1) : now;
               port_table[key] = e;
            end
         end
         ACT_CLEAR: begin
            if (in_range) begin
               port_table.delete(key);
            end
         end
         ACT_EXPIRE_SWEEP: begin
            foreach (port_table[k]) begin
               if (entry_stale(port_table[k], now)) begin
                  stale_keys.push_back(k);
               end
            end
            foreach (stale_keys[i]) begin
               port_table.delete(stale_keys[i]);
            end
         end
         ACT_CLEAR_ALL: begin
            port_table.delete();
         end
         default: begin
         end
      endcase
      return answer;
   endfunction

   always @(posedge clock) begin : monitor
      answer_type item;
      if (reset) begin
         port_table.delete();
         expected_answers.delete();
         ttl             = TTL_RESET;
         mismatch_count  = 0;
         items_seen      = 0;
         answers_checked = 0;
         table_passes    = 0;
      end else begin
         if (csr_wr_en) begin
            ttl = csr_wr_data;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_answers.size() == 0) begin
               report_mismatch($sformatf("answer %b with no item outstanding", rsp_mon.answer));
            end else begin
               item = expected_answers.pop_front();
               answers_checked++;
               if (rsp_mon.answer !== item.answer) begin
                  report_mismatch($sformatf("action %0d port %0d now %h: answer %b, expected %b",
                     item.action, item.port, item.time_bucket, rsp_mon.answer, item.answer));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            item.action      = req_mon.action;
            item.port        = req_mon.port;
            item.time_bucket = req_mon.time_bucket;
            item.answer      = predict_answer(req_mon.action, req_mon.port,
                                              req_mon.time_bucket);
            expected_answers.push_back(item);
            items_seen++;
            if (req_mon.action == ACT_EXPIRE_SWEEP || req_mon.action == ACT_CLEAR_ALL) begin
               table_passes++;
            end
         end
      end
      outstanding <= expected_answers.size();
   end

endmodule

// ----- tb/sv/port_decision_ttl_table_test.sv -----
// Top of the decision table testbench: clock, reset, CSR writes, request stimulus and
// response back-pressure, watchdog and verdict. Checking is done by pdtt_answer_checker.
// Depends on pdtt_pkg, the channel interfaces, the checker and port_decision_ttl_table.
`timescale 1ns / 100ps

module port_decision_ttl_table_test import pdtt_pkg::*; ();

   localparam logic [ACTION_W-1:0] ACT_UNDEFINED = 3'd7;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int LONG_GAP_MAX    = 40;
   localparam int WATCHDOG_LIMIT  = 4 * (PORT_COUNT_DEF + 3 + HOLD_OFF_CYCLES + LONG_GAP_MAX);
   localparam int TAIL_CYCLES     = 16;
   localparam int HOT_PORTS       = 12;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [TTL_W-1:0] csr_wr_data;

   int outstanding, mismatch_count, items_seen, answers_checked, table_passes;

   int               tx_idle_pct   = 0;
   int               rx_idle_pct   = 0;
   bit               hold_off_req  = 1'b0;
   int               passes_left   = 6;
   logic [TTL_W-1:0] ttl_setting   = TTL_RESET;
   logic [NOW_W-1:0] now_cursor    = '0;
   logic [PORT_W-1:0] hot_ports[HOT_PORTS];

   pdtt_req_if req_ch ();
   pdtt_rsp_if rsp_ch ();

   port_decision_ttl_table dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   pdtt_answer_checker answer_check (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .outstanding     (outstanding),
      .mismatch_count  (mismatch_count),
      .items_seen      (items_seen),
      .answers_checked (answers_checked),
      .table_passes    (table_passes)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(8, LONG_GAP_MAX);
      end
      return $urandom_range(1, 3);
   endfunction

   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [PORT_W-1:0] port,
                            input logic [NOW_W-1:0] now);
      int gap;
      gap = 0;
      if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         gap = gap_length();
      end
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= act;
      req_ch.port        <= port;
      req_ch.time_bucket <= now;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_ttl(input logic [TTL_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      ttl_setting  = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random_item();
      int                  roll;
      logic [ACTION_W-1:0] act;
      logic [PORT_W-1:0]   port;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         // same bucket
      end else if (roll < 85) begin
         now_cursor += $urandom_range(1, 3);
      end else if (roll < 95) begin
         now_cursor += $urandom_range(0, ttl_setting + 2);
      end else if (roll < 98) begin
         now_cursor -= $urandom_range(1, 4);
      end else begin
         now_cursor = $urandom();
      end
      if ($urandom_range(0, 99) < 85) begin
         port = hot_ports[$urandom_range(0, HOT_PORTS - 1)];
      end else begin
         port = PORT_W'($urandom_range(0, 65535));
      end
      roll = $urandom_range(0, 999);
      if (roll >= 997 && passes_left > 0) begin
         passes_left--;
         act = ($urandom_range(0, 2) != 0) ? ACT_EXPIRE_SWEEP : ACT_CLEAR_ALL;
      end else if (roll < 300) begin
         act = ACT_QUERY_DECIDED;
      end else if (roll < 450) begin
         act = ACT_QUERY_DIRECT;
      end else if (roll < 610) begin
         act = ACT_SET_DIRECT;
      end else if (roll < 800) begin
         act = ACT_SET_DECIDED;
      end else if (roll < 880) begin
         act = ACT_CLEAR;
      end else if (roll < 900) begin
         act = ACT_UNDEFINED;
      end else begin
         act = ACT_QUERY_DECIDED;
      end
      send_item(act, port, now_cursor);
   endtask

   task automatic run_phase(input logic [TTL_W-1:0] ttl, input int count, input int tx_pct,
                            input int rx_pct, input bit hold_off, input logic [NOW_W-1:0] start);
      wait_drained();
      write_ttl(ttl);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      now_cursor  = start;
      if (hold_off) begin
         hold_off_req = 1'b1;
      end
      repeat (count) send_random_item();
   endtask

   initial begin : rsp_drain
      int stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall        = HOLD_OFF_CYCLES;
         end else if (stall == 0 && rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            stall = gap_length();
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("port_decision_ttl_table verification failed");
      $finish;
   end

   initial begin : stimulus
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= TTL_RESET;
      req_ch.valid       <= 1'b0;
      req_ch.action      <= ACT_QUERY_DECIDED;
      req_ch.port        <= '0;
      req_ch.time_bucket <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      hot_ports[0] = '0;
      hot_ports[1] = '1;
      for (int i = 2; i < HOT_PORTS; i++) begin
         hot_ports[i] = PORT_W'($urandom_range(0, 65535));
      end

      // directed: ttl at its reset value of 30
      send_item(ACT_QUERY_DECIDED, 16'h0000, 32'd5);          // unused entry
      send_item(ACT_QUERY_DIRECT,  16'hFFFF, 32'd5);
      send_item(ACT_SET_DIRECT,    16'h0000, 32'd0);          // bucket 0 stamps as 1
      send_item(ACT_QUERY_DIRECT,  16'h0000, 32'd0);
      send_item(ACT_QUERY_DECIDED, 16'h0000, 32'd31);         // age equals ttl
      send_item(ACT_QUERY_DECIDED, 16'h0000, 32'd32);         // one past ttl, clears
      send_item(ACT_QUERY_DIRECT,  16'h0000, 32'd32);
      send_item(ACT_SET_DECIDED,   16'hFFFF, 32'hFFFF_FFF0);
      send_item(ACT_QUERY_DECIDED, 16'hFFFF, 32'h0000_000D);  // age across the wrap
      send_item(ACT_QUERY_DIRECT,  16'hFFFF, 32'h0000_000D);
      send_item(ACT_SET_DIRECT,    16'h5A5A, 32'd100);
      send_item(ACT_CLEAR,         16'h5A5A, 32'd100);
      send_item(ACT_QUERY_DIRECT,  16'h5A5A, 32'd100);
      send_item(ACT_SET_DIRECT,    16'hA5A5, 32'd200);
      send_item(ACT_SET_DECIDED,   16'h0001, 32'd1000);
      send_item(ACT_EXPIRE_SWEEP,  16'h1234, 32'd1020);
      send_item(ACT_QUERY_DIRECT,  16'hA5A5, 32'd1020);
      send_item(ACT_QUERY_DECIDED, 16'h0001, 32'd1030);
      send_item(ACT_UNDEFINED,     16'h0001, 32'd1030);
      send_item(ACT_SET_DIRECT,    16'h0002, 32'hFFFF_FFFF);
      send_item(ACT_CLEAR_ALL,     16'hFFFF, 32'hFFFF_FFFF);
      send_item(ACT_QUERY_DECIDED, 16'h0001, 32'd1030);
      send_item(ACT_QUERY_DIRECT,  16'h0002, 32'd1030);
      send_item(ACT_SET_DECIDED,   16'h0003, 32'd500);
      send_item(ACT_QUERY_DECIDED, 16'h0003, 32'd499);        // stamp ahead of now

      run_phase(16'd0,     200, 20, 20, 1'b0, $urandom());
      run_phase(16'hFFFF,  150,  0,  0, 1'b0, $urandom());
      run_phase(TTL_W'($urandom_range(1, 64)), 200, 30, 30, 1'b0, 32'hFFFF_FFC0);
      run_phase(16'd8,     150,  0,  0, 1'b1, $urandom());
      run_phase(16'd3,     150, 10, 50, 1'b0, 32'hFFFF_FFF8);
      run_phase(TTL_W'($urandom_range(0, 65535)), 150, 25, 25, 1'b0, $urandom());

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d items and %0d compared answers, %0d full-table passes",
               items_seen, answers_checked, table_passes);
      $display("TTL swept from 0 to 65535 with wrapping time, idle gaps and a %0d-cycle hold-off",
               HOLD_OFF_CYCLES);
      if (mismatch_count == 0) begin
         $display("port_decision_ttl_table verification clean");
      end else begin
         $display("port_decision_ttl_table verification failed");
      end
      $finish;
   end

endmodule

// ----- port_decision_ttl_table.f -----
src/pdtt_pkg.sv
src/pdtt_chan_if.sv
src/pdtt_ram.sv
src/pdtt_ctrl.sv
src/port_decision_ttl_table.sv
tb/sv/pdtt_answer_checker.sv
tb/sv/port_decision_ttl_table_test.sv
